// ===== rtl/kxp_pkg.sv =====
package kxp_pkg;

  localparam int unsigned MAX_SLOTS = 128;
  localparam int unsigned SLOT_AW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CFG_W     = 8;
  // common width for comparing the slot index against k
  localparam int unsigned KCMP_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam int unsigned PRICE_W   = 16;
  localparam int unsigned BAL_W     = 32;
  localparam int unsigned PROFIT_W  = 31;
  localparam int unsigned SUM_W     = BAL_W + 2;

  localparam logic signed [BAL_W-1:0] HOLD_RESET = {1'b1, {(BAL_W-1){1'b0}}};
  localparam logic signed [BAL_W-1:0] REL_RESET  = '0;
  localparam logic signed [BAL_W-1:0] PROFIT_TOP = {1'b0, {(BAL_W-1){1'b1}}};

  localparam logic [CFG_W-1:0] K_RESET = CFG_W'(1);

  typedef struct packed {
    logic signed [BAL_W-1:0] hold;
    logic signed [BAL_W-1:0] rel;
  } slot_t;

endpackage

// ===== rtl/kxp_if.sv =====
interface kxp_day_if;
  import kxp_pkg::*;
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] price;
  logic               last_day;

  modport source (output valid, price, last_day, input ready);
  modport sink   (input valid, price, last_day, output ready);
endinterface

interface kxp_res_if;
  import kxp_pkg::*;
  logic                valid;
  logic                ready;
  logic [PROFIT_W-1:0] best_profit;
  logic                is_final;

  modport source (output valid, best_profit, is_final, input ready);
  modport sink   (input valid, best_profit, is_final, output ready);
endinterface

interface kxp_cfg_if;
  import kxp_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] max_transactions;

  modport source (output valid, max_transactions, input ready);
  modport sink   (input valid, max_transactions, output ready);
endinterface

// ===== rtl/kxp_ram.sv =====
module kxp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/kxp_slot_upd.sv =====
module kxp_slot_upd import kxp_pkg::*; (
  input  logic [PRICE_W-1:0]      price_i,
  input  logic signed [BAL_W-1:0] prev_rel_i,
  input  slot_t                   old_i,
  output slot_t                   new_o
);

  logic signed [SUM_W-1:0] price_s;
  logic signed [SUM_W-1:0] sell_raw;
  logic signed [SUM_W-1:0] buy;
  logic signed [BAL_W-1:0] sell_sat;
  logic signed [BAL_W-1:0] sell;

  // sell after an improved buy equals prev_rel, so both sums run in parallel
  always_comb begin
    price_s  = signed'(SUM_W'(price_i));
    sell_raw = SUM_W'(old_i.hold) + price_s;
    buy      = SUM_W'(prev_rel_i) - price_s;

    sell_sat = (sell_raw > SUM_W'(PROFIT_TOP)) ? PROFIT_TOP : sell_raw[BAL_W-1:0];
    sell     = (sell_sat > prev_rel_i) ? sell_sat : prev_rel_i;

    new_o.hold = (buy > SUM_W'(old_i.hold)) ? buy[BAL_W-1:0] : old_i.hold;
    new_o.rel  = (sell > old_i.rel) ? sell : old_i.rel;
  end

endmodule

// ===== rtl/k_transaction_max_profit.sv =====
// Channel  | Dir | Payload                          | Beat when
// day_i    | in  | price[15:0], last_day            | valid & ready
// res_o    | out | best_profit[30:0], is_final      | valid & ready
// cfg_i    | in  | max_transactions[7:0]            | valid & ready
//
// Each day walks all MAX_SLOTS slots through the two slot memories, one
// read-modify-write per cycle with the write in the cycle after the read. The
// flush state then loads the output register and returns to idle together,
// so the result is valid in the same cycle that the next day can be taken.
// The result sits in an output register; a stalled res_o only holds the
// walk's end once a second result is ready. Reset clears the per-slot valid
// bits at once (no clearing pass); the day marked last clears them again.
module k_transaction_max_profit import kxp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  kxp_day_if.sink   day_i,
  kxp_res_if.source res_o,
  kxp_cfg_if.sink   cfg_i
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [CNT_W-1:0]        rd_cnt_q, rd_cnt_d;
  logic                    stg_vld_q, stg_vld_d;
  logic [SLOT_AW-1:0]      stg_idx_q, stg_idx_d;
  logic                    ent_vld_q, ent_vld_d;
  logic signed [BAL_W-1:0] prev_rel_q, prev_rel_d;
  logic [PROFIT_W-1:0]     best_q, best_d;
  logic [MAX_SLOTS-1:0]    vld_q, vld_d;
  logic                    out_vld_q, out_vld_d;
  logic                    last_q, last_d;
  logic [CFG_W-1:0]        k_q;
  logic [PRICE_W-1:0]      price_q;
  logic [PROFIT_W-1:0]     out_best_q;
  logic                    out_final_q;

  logic                    day_acc;
  logic                    rd_en;
  logic [SLOT_AW-1:0]      rd_addr;
  logic                    flush_go;
  logic                    walk_end;
  logic                    tgt_hit;
  logic [KCMP_W-1:0]       k_wide, k_eff;
  logic [BAL_W-1:0]        hold_rd, rel_rd;
  slot_t                   slot_old, slot_new;

  assign day_acc   = day_i.valid && day_i.ready;
  assign day_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign rd_en   = (state_q == ST_WALK) && (rd_cnt_q < CNT_W'(MAX_SLOTS));
  assign rd_addr = rd_cnt_q[SLOT_AW-1:0];

  kxp_ram #(.WIDTH(BAL_W), .DEPTH(MAX_SLOTS)) u_hold_ram (
    .clk_i   (clk_i),
    .we_i    (stg_vld_q),
    .waddr_i (stg_idx_q),
    .wdata_i (slot_new.hold),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (hold_rd)
  );

  kxp_ram #(.WIDTH(BAL_W), .DEPTH(MAX_SLOTS)) u_rel_ram (
    .clk_i   (clk_i),
    .we_i    (stg_vld_q),
    .waddr_i (stg_idx_q),
    .wdata_i (slot_new.rel),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rel_rd)
  );

  // an entry not written since the last clear reads as its reset value
  assign slot_old.hold = ent_vld_q ? signed'(hold_rd) : HOLD_RESET;
  assign slot_old.rel  = ent_vld_q ? signed'(rel_rd)  : REL_RESET;

  kxp_slot_upd u_upd (
    .price_i    (price_q),
    .prev_rel_i (prev_rel_q),
    .old_i      (slot_old),
    .new_o      (slot_new)
  );

  assign k_wide  = KCMP_W'(k_q);
  assign k_eff   = (k_wide > KCMP_W'(MAX_SLOTS)) ? KCMP_W'(MAX_SLOTS) : k_wide;
  assign tgt_hit = stg_vld_q && (k_eff != '0) &&
                   (KCMP_W'(stg_idx_q) == (k_eff - KCMP_W'(1)));
  assign walk_end = stg_vld_q && (stg_idx_q == SLOT_AW'(MAX_SLOTS - 1));
  assign flush_go = (state_q == ST_FLUSH) && (!out_vld_q || res_o.ready);

  always_comb begin
    state_d    = state_q;
    rd_cnt_d   = rd_cnt_q;
    stg_vld_d  = 1'b0;
    stg_idx_d  = stg_idx_q;
    ent_vld_d  = ent_vld_q;
    prev_rel_d = prev_rel_q;
    best_d     = best_q;
    vld_d      = vld_q;
    last_d     = last_q;
    out_vld_d  = out_vld_q;

    if (out_vld_q && res_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (day_acc) begin
          state_d    = ST_WALK;
          rd_cnt_d   = '0;
          prev_rel_d = '0;
          best_d     = '0;
          last_d     = day_i.last_day;
        end
      end
      ST_WALK: begin
        if (rd_en) begin
          rd_cnt_d  = rd_cnt_q + CNT_W'(1);
          stg_vld_d = 1'b1;
          stg_idx_d = rd_addr;
          ent_vld_d = vld_q[rd_addr];
        end
        if (stg_vld_q) begin
          prev_rel_d       = slot_new.rel;
          vld_d[stg_idx_q] = 1'b1;
        end
        if (tgt_hit) begin
          best_d = slot_new.rel[PROFIT_W-1:0];
        end
        if (walk_end) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (flush_go) begin
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
          if (last_q) begin
            vld_d = '0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_cnt_q   <= '0;
      stg_vld_q  <= 1'b0;
      stg_idx_q  <= '0;
      ent_vld_q  <= 1'b0;
      prev_rel_q <= '0;
      best_q     <= '0;
      vld_q      <= '0;
      last_q     <= 1'b0;
      out_vld_q  <= 1'b0;
      k_q        <= K_RESET;
    end else begin
      state_q    <= state_d;
      rd_cnt_q   <= rd_cnt_d;
      stg_vld_q  <= stg_vld_d;
      stg_idx_q  <= stg_idx_d;
      ent_vld_q  <= ent_vld_d;
      prev_rel_q <= prev_rel_d;
      best_q     <= best_d;
      vld_q      <= vld_d;
      last_q     <= last_d;
      out_vld_q  <= out_vld_d;
      if (cfg_i.valid && cfg_i.ready) begin
        k_q <= cfg_i.max_transactions;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (day_acc) begin
      price_q <= day_i.price;
    end
    if (flush_go) begin
      out_best_q  <= best_q;
      out_final_q <= last_q;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.best_profit = out_best_q;
  assign res_o.is_final    = out_final_q;

`ifndef SYNTHESIS
  a_wr_follows_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_vld_q |-> $past(rd_en) && (stg_idx_q == $past(rd_addr)))
    else $error("slot write does not follow its read");

  a_rel_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_vld_q |-> !prev_rel_q[BAL_W-1])
    else $error("released balance went negative");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flush_go && last_q) |=> (vld_q == '0))
    else $error("slot valid bits not cleared after last day");

  a_walk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> $past(state_q == ST_FLUSH) || $past(walk_end))
    else $error("flush entered before walk finished");
`endif

endmodule

// ===== tb/k_transaction_max_profit_tb.sv =====
module k_transaction_max_profit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kxp_pkg::*;

  typedef enum int {STYLE_RANDOM, STYLE_ZIGZAG, STYLE_NARROW} price_style_e;

  class profit_scoreboard;
    typedef struct {
      logic [PROFIT_W-1:0] profit;
      logic                fin;
    } profit_beat_t;

    longint          hold_bal[MAX_SLOTS];
    longint          rel_bal[MAX_SLOTS];
    logic [CFG_W-1:0] k_reg;
    profit_beat_t    expected_profits[$];
    int              errors;

    function new();
      clear_slots();
      k_reg  = K_RESET;
      errors = 0;
    endfunction

    function void clear_slots();
      for (int j = 0; j < MAX_SLOTS; j++) begin
        hold_bal[j] = longint'(HOLD_RESET);
        rel_bal[j]  = longint'(REL_RESET);
      end
    endfunction

    function void set_k(logic [CFG_W-1:0] k);
      k_reg = k;
    endfunction

    function int pending();
      return expected_profits.size();
    endfunction

    // walk every slot whatever k is, so a new k is exact straight away
    function void note_day(logic [PRICE_W-1:0] price, logic last_day);
      longint       px;
      longint       prev_rel;
      longint       buy;
      longint       sell;
      longint       best;
      int           kk;
      profit_beat_t beat;
      px       = longint'(price);
      prev_rel = 0;
      for (int j = 0; j < MAX_SLOTS; j++) begin
        buy = prev_rel - px;
        if (buy > hold_bal[j]) hold_bal[j] = buy;
        sell = hold_bal[j] + px;
        if (sell > longint'(PROFIT_TOP)) sell = longint'(PROFIT_TOP);
        if (sell > rel_bal[j]) rel_bal[j] = sell;
        prev_rel = rel_bal[j];
      end
      kk   = (int'(k_reg) > MAX_SLOTS) ? MAX_SLOTS : int'(k_reg);
      best = (kk > 0) ? rel_bal[kk-1] : 0;
      beat.profit = best[PROFIT_W-1:0];
      beat.fin    = last_day;
      expected_profits.push_back(beat);
      if (last_day) clear_slots();
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(logic [PROFIT_W-1:0] profit, logic fin);
      profit_beat_t want;
      if (expected_profits.size() == 0) begin
        report_mismatch("unexpected result beat", longint'(profit), -1);
        return;
      end
      want = expected_profits.pop_front();
      if (profit !== want.profit) report_mismatch("best_profit", longint'(profit), longint'(want.profit));
      if (fin !== want.fin) report_mismatch("is_final", longint'(fin), longint'(want.fin));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  kxp_day_if day_if ();
  kxp_res_if res_if ();
  kxp_cfg_if cfg_if ();

  k_transaction_max_profit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .day_i  (day_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  profit_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_off_left  = 0;
  int day_count      = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(8_000_000);
    $display("tb: failure");
    $finish;
  end

  // result side: check every beat, stall at random or for a long hold-off
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) sb.check_result(res_if.best_profit, res_if.is_final);
      if (hold_off_left > 0) begin
        res_if.ready <= 1'b0;
        hold_off_left--;
      end else begin
        res_if.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // valid stays high between back-to-back beats; lowered only for a gap
  task automatic send_day(input logic [PRICE_W-1:0] price, input logic last_day);
    while ($urandom_range(99) < send_idle_pct) begin
      day_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    day_if.valid    <= 1'b1;
    day_if.price    <= price;
    day_if.last_day <= last_day;
    do @(posedge clk_i); while (!day_if.ready);
    sb.note_day(price, last_day);
    day_count++;
  endtask

  task automatic wait_drained();
    day_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_k(input logic [CFG_W-1:0] k);
    wait_drained();
    cfg_if.valid            <= 1'b1;
    cfg_if.max_transactions <= k;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.set_k(k);
  endtask

  task automatic send_sequence(input int len, input price_style_e style, input bit close);
    logic [PRICE_W-1:0] p;
    for (int i = 0; i < len; i++) begin
      case (style)
        STYLE_ZIGZAG: begin
          p = (i % 2) ? PRICE_W'($urandom_range(65535, 60000))
                      : PRICE_W'($urandom_range(5000, 0));
        end
        STYLE_NARROW: p = PRICE_W'($urandom_range(300, 0));
        default:      p = PRICE_W'($urandom);
      endcase
      send_day(p, close && (i == len - 1));
    end
  endtask

  initial begin
    logic [CFG_W-1:0] k_plan[8];
    int               phase_end;
    int               len;
    price_style_e     style;

    rst_ni                  <= 1'b0;
    day_if.valid            <= 1'b0;
    day_if.price            <= '0;
    day_if.last_day         <= 1'b0;
    cfg_if.valid            <= 1'b0;
    cfg_if.max_transactions <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // k = 1 from reset: single day, then simple gains
    send_day(16'hFFFF, 1'b1);
    send_day(16'h0000, 1'b0);
    send_day(16'hFFFF, 1'b1);
    send_day(16'hFFFF, 1'b0);
    send_day(16'h0000, 1'b0);
    send_day(16'hFFFF, 1'b0);
    send_day(16'h0000, 1'b0);
    send_day(16'hFFFF, 1'b1);

    // zero transactions
    write_k(8'd0);
    send_day(16'd10, 1'b0);
    send_day(16'd20, 1'b1);

    // k beyond the slot count clamps
    write_k(8'd255);
    for (int i = 0; i < 8; i++) send_day((i % 2) ? 16'hFFFF : 16'h0000, i == 7);

    // k changed part way through a sequence
    write_k(8'd2);
    send_day(16'd5, 1'b0);
    send_day(16'd100, 1'b0);
    send_day(16'd3, 1'b0);
    write_k(8'd128);
    send_day(16'd200, 1'b0);
    send_day(16'd1, 1'b0);
    send_day(16'd300, 1'b1);

    k_plan = '{8'd128, 8'd1, 8'd0, 8'd2, 8'd255, 8'd127,
               CFG_W'($urandom_range(255, 0)), CFG_W'($urandom_range(128, 1))};
    for (int p = 0; p < 8; p++) begin
      write_k(k_plan[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      // long hold-off on the result side while days keep coming
      if (p == 4) hold_off_left = 400;
      phase_end = day_count + 250;
      while (day_count < phase_end) begin
        len   = ($urandom_range(9) == 0) ? $urandom_range(300, 41) : $urandom_range(40, 1);
        style = price_style_e'($urandom_range(2, 0));
        // the odd sequence is left open so it runs into the next one, possibly under the next k
        send_sequence(len, style, $urandom_range(7) != 0);
      end
    end

    wait_drained();
    repeat (MAX_SLOTS + 16) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/kxp_pkg.sv
rtl/kxp_if.sv
rtl/kxp_ram.sv
rtl/kxp_slot_upd.sv
rtl/k_transaction_max_profit.sv
tb/k_transaction_max_profit_tb.sv
